[hw/rtl/isqrt_pkg.sv]
// shared types, constants and microcode for the integer square root block
package isqrt_pkg;

  // widths of the item fields
  localparam int DATA_W  = 64;
  localparam int WCODE_W = 2;

  // widest operand the block handles, in bits (8 to 64)
  localparam int MAX_WIDTH = 64;

  // microprogram counter
  localparam int STEP_W = 2;

  // step addresses
  localparam logic [STEP_W-1:0] STEP_WAIT  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 2'd1;
  localparam logic [STEP_W-1:0] STEP_ITER  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

  // jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] COND_NO_INPUT = 3'd1;
  localparam logic [COND_W-1:0] COND_NEG      = 3'd2;
  localparam logic [COND_W-1:0] COND_NOT_LAST = 3'd3;
  localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd4;

  // width codes
  localparam logic [WCODE_W-1:0] WCODE_8  = 2'd0;
  localparam logic [WCODE_W-1:0] WCODE_16 = 2'd1;
  localparam logic [WCODE_W-1:0] WCODE_32 = 2'd2;
  localparam logic [WCODE_W-1:0] WCODE_64 = 2'd3;

  // one control word
  typedef struct packed {
    logic              accept;
    logic              iter;
    logic              emit;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // status flags fed back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic neg;
    logic last;
    logic out_busy;
  } stat_t;

  // per-width operand setup
  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] start_bit;
    logic [DATA_W-1:0] sign_bit;
  } wsetup_t;

  // microprogram rom
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      // wait for an item, stay here while none is offered
      STEP_WAIT: begin
        c.accept = 1'b1;
        c.cond   = COND_NO_INPUT;
        c.target = STEP_WAIT;
      end
      // negative operands skip the root
      STEP_CHECK: begin
        c.cond   = COND_NEG;
        c.target = STEP_EMIT;
      end
      // one root bit per pass
      STEP_ITER: begin
        c.iter   = 1'b1;
        c.cond   = COND_NOT_LAST;
        c.target = STEP_ITER;
      end
      // hand result to output register, then wrap to wait
      STEP_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.target = STEP_EMIT;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  // effective width in bits, capped at MAX_WIDTH
  function automatic int eff_width(input logic [WCODE_W-1:0] code);
    int w;
    case (code)
      WCODE_8:  w = 8;
      WCODE_16: w = 16;
      WCODE_32: w = 32;
      WCODE_64: w = 64;
      default:  w = 64;
    endcase
    if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    return w;
  endfunction

  // mask, first trial bit (even position) and sign bit for a width code
  function automatic wsetup_t width_setup(input logic [WCODE_W-1:0] code);
    wsetup_t s;
    int      w;
    w = eff_width(code);
    if (w >= DATA_W) begin
      s.mask = '1;
    end else begin
      s.mask = (DATA_W'(1) << w) - DATA_W'(1);
    end
    s.start_bit = DATA_W'(1) << ((w - 1) & ~1);
    s.sign_bit  = DATA_W'(1) << (w - 1);
    return s;
  endfunction

endpackage

[hw/rtl/integer_square_root_top.sv]
// top level: floor square root with a microcoded digit-by-digit datapath
// operand widths 8/16/32/64 bits; an accepted item goes from the wait step to the check step, then
// a negative signed operand goes straight to the emit step, any other item gets one root bit per
// pass of the iterate step until the last root bit and then goes to the emit step; the output
// register lets the next item enter while a result waits
// rst_n is synchronous: sequencer returns to wait, output valid clears
module integer_square_root_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [isqrt_pkg::DATA_W-1:0]      in_operand,
  input  logic [isqrt_pkg::WCODE_W-1:0]     in_width_code,
  input  logic                              in_is_signed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [isqrt_pkg::DATA_W-1:0]      out_root
);

  isqrt_pkg::ctrl_t    ctrl;
  isqrt_pkg::stat_t    stat;
  isqrt_pkg::wsetup_t  setup;

  logic [isqrt_pkg::DATA_W-1:0] x_r, x_nxt;
  logic [isqrt_pkg::DATA_W-1:0] res_r, res_nxt;
  logic [isqrt_pkg::DATA_W-1:0] bit_r, bit_nxt;
  logic                         neg_r, neg_nxt;
  logic [isqrt_pkg::DATA_W-1:0] masked;
  logic [isqrt_pkg::DATA_W-1:0] trial;
  logic                         fits;
  logic                         accept;
  logic                         out_busy;
  logic                         emit_go;
  logic                         out_valid_r, out_valid_nxt;
  logic [isqrt_pkg::DATA_W-1:0] out_root_r;

  // sequencer
  isqrt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // input handshake
  assign in_stall = ~ctrl.accept;
  assign accept   = in_valid & ctrl.accept;

  // operand setup for the selected width
  assign setup  = isqrt_pkg::width_setup(in_width_code);
  assign masked = in_operand & setup.mask;

  // trial value: res and bit never overlap, so an or is the sum
  assign trial = res_r | bit_r;
  assign fits  = (x_r >= trial);

  // datapath next values
  always_comb begin
    x_nxt   = x_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    neg_nxt = neg_r;
    if (accept) begin
      x_nxt   = masked;
      res_nxt = '0;
      bit_nxt = setup.start_bit;
      neg_nxt = in_is_signed & ((masked & setup.sign_bit) != '0);
    end else if (ctrl.iter) begin
      if (fits) begin
        x_nxt   = x_r - trial;
        res_nxt = (res_r >> 1) | bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
  end

  // output register
  assign out_busy      = out_valid_r & out_stall;
  assign emit_go       = ctrl.emit & ~out_busy;
  assign out_valid_nxt = emit_go | out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_root_r <= neg_r ? x_r : res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

  // status back to the sequencer
  assign stat.in_valid = in_valid;
  assign stat.neg      = neg_r;
  assign stat.last     = bit_r[0];
  assign stat.out_busy = out_busy;

endmodule

[hw/rtl/isqrt_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
module isqrt_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  isqrt_pkg::stat_t                stat,
  output isqrt_pkg::ctrl_t                ctrl
);

  logic [isqrt_pkg::STEP_W-1:0] step_r;
  logic [isqrt_pkg::STEP_W-1:0] step_nxt;
  logic                         take_jump;

  // control word of the current step
  assign ctrl = isqrt_pkg::ucode_rom(step_r);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      isqrt_pkg::COND_NEXT:     take_jump = 1'b0;
      isqrt_pkg::COND_NO_INPUT: take_jump = ~stat.in_valid;
      isqrt_pkg::COND_NEG:      take_jump = stat.neg;
      isqrt_pkg::COND_NOT_LAST: take_jump = ~stat.last;
      isqrt_pkg::COND_OUT_BUSY: take_jump = stat.out_busy;
      default:                  take_jump = 1'b0;
    endcase
  end

  // next step: jump target or fall through (wraps to wait)
  assign step_nxt = take_jump ? ctrl.target : step_r + isqrt_pkg::STEP_W'(1);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= isqrt_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
